[rtl/pra_pkg.sv]
package pra_pkg;

	localparam int VALUE_W = 64;
	localparam int LEN_W   = 5;
	localparam int CNT_W   = 4;
	localparam int DATA_W  = 32;
	localparam int ADDR_W  = 4;

	typedef enum logic [1:0] {
		REQ_CHECK  = 2'd0,
		REQ_SET    = 2'd1,
		REQ_VERIFY = 2'd2,
		REQ_UNDEF  = 2'd3
	} req_type_t;

	typedef enum logic [1:0] {
		KIND_PIN = 2'd0,
		KIND_PUK = 2'd1,
		KIND_KEY = 2'd2,
		KIND_BAD = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ACC_NEVER       = 3'd0,
		ACC_PIN         = 3'd1,
		ACC_KEY         = 3'd2,
		ACC_PIN_OR_KEY  = 3'd3,
		ACC_PIN_AND_KEY = 3'd4,
		ACC_ALWAYS      = 3'd5
	} acc_cond_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_DENIED    = 3'd1,
		ST_BLOCKED   = 3'd2,
		ST_WRONG_LEN = 3'd3,
		ST_MISMATCH  = 3'd4,
		ST_BAD_KIND  = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		REG_PIN_MAX = 2'd0,
		REG_PUK_MAX = 2'd1,
		REG_KEY_MAX = 2'd2,
		REG_NONE    = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [CNT_W-1:0] pin_max;
		logic [CNT_W-1:0] puk_max;
		logic [CNT_W-1:0] key_max;
	} max_cfg_t;

	typedef struct packed {
		req_type_t          req_type;
		kind_t              ref_kind;
		acc_cond_t          access_condition;
		logic [VALUE_W-1:0] value_low;
		logic [VALUE_W-1:0] value_high;
		logic [LEN_W-1:0]   value_length;
	} req_t;

	typedef struct packed {
		status_t          status;
		logic [CNT_W-1:0] tries_left;
		logic             pin_verified;
		logic             key_verified;
	} rsp_t;

endpackage

[rtl/pra_cfg_regs.sv]
module pra_cfg_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pra_pkg::ADDR_W-1:0]  paddr,
	input  logic [pra_pkg::DATA_W-1:0]  pwdata,
	output logic [pra_pkg::DATA_W-1:0]  prdata,
	output pra_pkg::max_cfg_t           max_cfg
);
	import pra_pkg::*;

	logic     wr_en;
	reg_idx_t idx;
	max_cfg_t cfg_q;

	assign wr_en = psel & penable & pwrite;
	assign idx   = reg_idx_t'(paddr[ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pin_max <= CNT_W'(3);
			cfg_q.puk_max <= CNT_W'(10);
			cfg_q.key_max <= CNT_W'(3);
		end else if (wr_en) begin
			case (idx)
				REG_PIN_MAX: cfg_q.pin_max <= pwdata[CNT_W-1:0];
				REG_PUK_MAX: cfg_q.puk_max <= pwdata[CNT_W-1:0];
				REG_KEY_MAX: cfg_q.key_max <= pwdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_PIN_MAX: prdata = DATA_W'(cfg_q.pin_max);
			REG_PUK_MAX: prdata = DATA_W'(cfg_q.puk_max);
			REG_KEY_MAX: prdata = DATA_W'(cfg_q.key_max);
			default:     prdata = '0;
		endcase
	end

	assign max_cfg = cfg_q;

endmodule

[rtl/pra_auth_core.sv]
module pra_auth_core #(
	parameter int PIN_BYTES = 8,
	parameter int PUK_BYTES = 8,
	parameter int KEY_BYTES = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  pra_pkg::req_t     req,
	input  pra_pkg::max_cfg_t max_cfg,
	output pra_pkg::rsp_t     rsp
);
	import pra_pkg::*;

	localparam int PIN_W = PIN_BYTES * 8;
	localparam int PUK_W = PUK_BYTES * 8;
	localparam int KEY_W = KEY_BYTES * 8;

	// Reference values hold only the bytes that are compared.
	logic [PIN_W-1:0]     pin_ref_q;
	logic [PUK_W-1:0]     puk_ref_q;
	logic [KEY_W-1:0]     key_ref_q;
	logic [CNT_W-1:0]     pin_cnt_q, puk_cnt_q, key_cnt_q;
	logic                 pin_flag_q, key_flag_q;

	logic [2*VALUE_W-1:0] value_all;
	logic                 sel_len_ok, sel_match;
	logic [CNT_W-1:0]     sel_cnt, sel_max;
	logic                 access_ok;

	status_t              status;
	logic [CNT_W-1:0]     tries;
	logic                 pin_flag_d, key_flag_d;
	logic                 cnt_wr, ref_wr;
	logic [CNT_W-1:0]     cnt_new;

	assign value_all = {req.value_high, req.value_low};

	always_comb begin
		case (req.ref_kind)
			KIND_PIN: begin
				sel_len_ok = req.value_length == LEN_W'(PIN_BYTES);
				sel_match  = value_all[PIN_W-1:0] == pin_ref_q;
				sel_cnt    = pin_cnt_q;
				sel_max    = max_cfg.pin_max;
			end
			KIND_PUK: begin
				sel_len_ok = req.value_length == LEN_W'(PUK_BYTES);
				sel_match  = value_all[PUK_W-1:0] == puk_ref_q;
				sel_cnt    = puk_cnt_q;
				sel_max    = max_cfg.puk_max;
			end
			KIND_KEY: begin
				sel_len_ok = req.value_length == LEN_W'(KEY_BYTES);
				sel_match  = value_all[KEY_W-1:0] == key_ref_q;
				sel_cnt    = key_cnt_q;
				sel_max    = max_cfg.key_max;
			end
			default: begin
				sel_len_ok = 1'b0;
				sel_match  = 1'b0;
				sel_cnt    = '0;
				sel_max    = '0;
			end
		endcase
	end

	always_comb begin
		case (req.access_condition)
			ACC_PIN:         access_ok = pin_flag_q;
			ACC_KEY:         access_ok = key_flag_q;
			ACC_PIN_OR_KEY:  access_ok = pin_flag_q | key_flag_q;
			ACC_PIN_AND_KEY: access_ok = pin_flag_q & key_flag_q;
			ACC_ALWAYS:      access_ok = 1'b1;
			default:         access_ok = 1'b0;
		endcase
	end

	always_comb begin
		status     = ST_OK;
		tries      = '0;
		pin_flag_d = pin_flag_q;
		key_flag_d = key_flag_q;
		cnt_wr     = 1'b0;
		ref_wr     = 1'b0;
		cnt_new    = sel_max;
		case (req.req_type)
			REQ_CHECK: begin
				status = access_ok ? ST_OK : ST_DENIED;
			end
			REQ_SET: begin
				if (req.ref_kind == KIND_BAD) begin
					status = ST_BAD_KIND;
				end else if (!sel_len_ok) begin
					status = ST_WRONG_LEN;
				end else begin
					ref_wr = 1'b1;
					cnt_wr = 1'b1;
				end
			end
			REQ_VERIFY: begin
				if (req.ref_kind == KIND_BAD) begin
					status = ST_BAD_KIND;
				end else begin
					// A verify drops the flag first; only a full match raises it again.
					if (req.ref_kind == KIND_PIN) pin_flag_d = 1'b0;
					if (req.ref_kind == KIND_KEY) key_flag_d = 1'b0;
					if (!sel_len_ok) begin
						status = ST_WRONG_LEN;
					end else if (sel_cnt == '0) begin
						status = ST_BLOCKED;
					end else if (!sel_match) begin
						status  = ST_MISMATCH;
						cnt_wr  = 1'b1;
						cnt_new = sel_cnt - CNT_W'(1);
						tries   = sel_cnt - CNT_W'(1);
					end else begin
						cnt_wr = 1'b1;
						if (req.ref_kind == KIND_PIN) pin_flag_d = 1'b1;
						if (req.ref_kind == KIND_KEY) key_flag_d = 1'b1;
					end
				end
			end
			default: begin
				status = ST_BAD_KIND;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pin_flag_q <= 1'b0;
			key_flag_q <= 1'b0;
			pin_cnt_q  <= '0;
			puk_cnt_q  <= '0;
			key_cnt_q  <= '0;
		end else if (fire) begin
			pin_flag_q <= pin_flag_d;
			key_flag_q <= key_flag_d;
			if (cnt_wr) begin
				case (req.ref_kind)
					KIND_PIN: pin_cnt_q <= cnt_new;
					KIND_PUK: puk_cnt_q <= cnt_new;
					KIND_KEY: key_cnt_q <= cnt_new;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && ref_wr) begin
			case (req.ref_kind)
				KIND_PIN: pin_ref_q <= value_all[PIN_W-1:0];
				KIND_PUK: puk_ref_q <= value_all[PUK_W-1:0];
				KIND_KEY: key_ref_q <= value_all[KEY_W-1:0];
				default: ;
			endcase
		end
	end

	assign rsp.status       = status;
	assign rsp.tries_left   = tries;
	assign rsp.pin_verified = pin_flag_d;
	assign rsp.key_verified = key_flag_d;

endmodule

[rtl/pin_retry_auth_unit_top.sv]
// A request accepted into the request register moves on into the result register, and
// so onto the output ports, whenever the result register is free or being drained.
// Throughput: one request per cycle unless out_stall holds a full result register; flags
// and retry counters are read and updated in the single stage between the two registers.
// Reset (arst_n low) clears both flags and all retry counters, so every kind is
// blocked until set, and loads the retry maximums with 3, 10 and 3.
module pin_retry_auth_unit_top #(
	parameter int PIN_BYTES = 8,
	parameter int PUK_BYTES = 8,
	parameter int KEY_BYTES = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  req_type,
	input  logic [1:0]                  ref_kind,
	input  logic [2:0]                  access_condition,
	input  logic [pra_pkg::VALUE_W-1:0] value_low,
	input  logic [pra_pkg::VALUE_W-1:0] value_high,
	input  logic [pra_pkg::LEN_W-1:0]   value_length,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [2:0]                  status,
	output logic [pra_pkg::CNT_W-1:0]   tries_left,
	output logic                        pin_verified,
	output logic                        key_verified,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pra_pkg::ADDR_W-1:0]  paddr,
	input  logic [pra_pkg::DATA_W-1:0]  pwdata,
	output logic [pra_pkg::DATA_W-1:0]  prdata,
	output logic                        pready
);
	import pra_pkg::*;

	logic     valid_s1, valid_s2;
	req_t     req_s1;
	rsp_t     rsp_s2;
	rsp_t     rsp;
	max_cfg_t max_cfg;
	logic     accept, adv;

	assign pready = 1'b1;

	// The request stage moves on whenever the result register is empty or being drained.
	assign adv      = valid_s1 & (~valid_s2 | ~out_stall);
	assign in_stall = valid_s1 & ~adv;
	assign accept   = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept | (valid_s1 & ~adv);
			valid_s2 <= adv | (valid_s2 & out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1.req_type         <= req_type_t'(req_type);
			req_s1.ref_kind         <= kind_t'(ref_kind);
			req_s1.access_condition <= acc_cond_t'(access_condition);
			req_s1.value_low        <= value_low;
			req_s1.value_high       <= value_high;
			req_s1.value_length     <= value_length;
		end
		if (adv) begin
			rsp_s2 <= rsp;
		end
	end

	pra_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.max_cfg (max_cfg)
	);

	pra_auth_core #(
		.PIN_BYTES (PIN_BYTES),
		.PUK_BYTES (PUK_BYTES),
		.KEY_BYTES (KEY_BYTES)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (adv),
		.req     (req_s1),
		.max_cfg (max_cfg),
		.rsp     (rsp)
	);

	assign out_valid    = valid_s2;
	assign status       = rsp_s2.status;
	assign tries_left   = rsp_s2.tries_left;
	assign pin_verified = rsp_s2.pin_verified;
	assign key_verified = rsp_s2.key_verified;

endmodule

[bench/tb.sv]
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pra_pkg::*;

	localparam int PIN_LEN = 8;
	localparam int PUK_LEN = 8;
	localparam int KEY_LEN = 16;
	localparam int LONG_HOLD = 60;

	typedef struct {
		req_t rq;
		bit   drain;
	} backlog_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic in_valid = 1'b0;
	logic in_stall;
	req_t drv = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [2:0] status;
	logic [CNT_W-1:0] tries_left;
	logic pin_verified;
	logic key_verified;

	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;

	// Predicted card state.
	logic pin_ok;
	logic key_ok;
	logic [CNT_W-1:0] retry_cnt [3];
	logic [63:0] ref_word [4];
	logic [CNT_W-1:0] retry_limit [3];

	// Last stored value per kind, in the order the requests are queued.
	logic [63:0] stored_lo [3];
	logic [63:0] stored_hi;

	backlog_t req_backlog[$];
	rsp_t auth_expected[$];
	int errors = 0;
	int gap_left = 0;
	int stall_left = 0;
	bit idle_on = 1'b1;
	bit hold_req = 1'b0;

	pin_retry_auth_unit_top #(
		.PIN_BYTES(PIN_LEN),
		.PUK_BYTES(PUK_LEN),
		.KEY_BYTES(KEY_LEN)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(drv.req_type),
		.ref_kind(drv.ref_kind),
		.access_condition(drv.access_condition),
		.value_low(drv.value_low),
		.value_high(drv.value_high),
		.value_length(drv.value_length),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.tries_left(tries_left),
		.pin_verified(pin_verified),
		.key_verified(key_verified),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #1 clk = ~clk;

	function automatic int kind_bytes(input kind_t k);
		if (k == KIND_PIN) return PIN_LEN;
		if (k == KIND_PUK) return PUK_LEN;
		return KEY_LEN;
	endfunction

	function automatic logic [63:0] byte_mask(input int n);
		if (n <= 0) return 64'd0;
		if (n >= 8) return '1;
		return (64'd1 << (8 * n)) - 64'd1;
	endfunction

	function automatic rsp_t auth_outcome(input req_t rq);
		rsp_t r;
		int n;
		int k;
		int w;
		logic [63:0] mlo;
		logic [63:0] mhi;
		logic [63:0] diff;
		logic grant;
		r.status = ST_OK;
		r.tries_left = '0;
		if (rq.req_type == REQ_CHECK) begin
			case (rq.access_condition)
				ACC_PIN: grant = pin_ok;
				ACC_KEY: grant = key_ok;
				ACC_PIN_OR_KEY: grant = pin_ok | key_ok;
				ACC_PIN_AND_KEY: grant = pin_ok & key_ok;
				ACC_ALWAYS: grant = 1'b1;
				default: grant = 1'b0;
			endcase
			r.status = grant ? ST_OK : ST_DENIED;
		end else if (rq.req_type == REQ_UNDEF || rq.ref_kind == KIND_BAD) begin
			r.status = ST_BAD_KIND;
		end else begin
			k = int'(rq.ref_kind);
			n = kind_bytes(rq.ref_kind);
			mlo = byte_mask(n);
			mhi = (rq.ref_kind == KIND_KEY) ? byte_mask(n - 8) : 64'd0;
			w = k;
			if (rq.req_type == REQ_VERIFY) begin
				if (rq.ref_kind == KIND_PIN) pin_ok = 1'b0;
				if (rq.ref_kind == KIND_KEY) key_ok = 1'b0;
			end
			if (int'(rq.value_length) != n) begin
				r.status = ST_WRONG_LEN;
			end else if (rq.req_type == REQ_SET) begin
				ref_word[w] = rq.value_low & mlo;
				if (rq.ref_kind == KIND_KEY) ref_word[3] = rq.value_high & mhi;
				retry_cnt[k] = retry_limit[k];
			end else if (retry_cnt[k] == '0) begin
				r.status = ST_BLOCKED;
			end else begin
				diff = (ref_word[w] ^ rq.value_low) & mlo;
				if (rq.ref_kind == KIND_KEY) diff |= (ref_word[3] ^ rq.value_high) & mhi;
				if (diff != 64'd0) begin
					retry_cnt[k] = retry_cnt[k] - 1'b1;
					r.tries_left = retry_cnt[k];
					r.status = ST_MISMATCH;
				end else begin
					retry_cnt[k] = retry_limit[k];
					if (rq.ref_kind == KIND_PIN) pin_ok = 1'b1;
					if (rq.ref_kind == KIND_KEY) key_ok = 1'b1;
				end
			end
		end
		r.pin_verified = pin_ok;
		r.key_verified = key_ok;
		return r;
	endfunction

	function automatic int rand_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(6, 25);
	endfunction

	function automatic logic [63:0] rand_word();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 64'd0;
		if (r == 1) return '1;
		return {$urandom, $urandom};
	endfunction

	function automatic req_t item(input req_type_t rt, input kind_t k, input acc_cond_t ac,
			input logic [63:0] lo, input logic [63:0] hi, input int len);
		req_t rq;
		rq.req_type = rt;
		rq.ref_kind = k;
		rq.access_condition = ac;
		rq.value_low = lo;
		rq.value_high = hi;
		rq.value_length = LEN_W'(len);
		return rq;
	endfunction

	function automatic req_t make_item();
		req_t rq;
		int r;
		int pos;
		kind_t k;
		rq = item(REQ_CHECK, kind_t'($urandom_range(0, 3)), acc_cond_t'($urandom_range(0, 7)),
			rand_word(), rand_word(), $urandom_range(0, 31));
		r = $urandom_range(0, 99);
		k = kind_t'($urandom_range(0, 2));
		if (r < 12) begin
			return rq;
		end else if (r < 30) begin
			rq.req_type = REQ_SET;
			rq.ref_kind = k;
			rq.value_length = LEN_W'(kind_bytes(k));
		end else if (r < 75) begin
			rq.req_type = REQ_VERIFY;
			rq.ref_kind = k;
			rq.value_length = LEN_W'(kind_bytes(k));
			if ($urandom_range(0, 9) < 6) begin
				rq.value_low = stored_lo[int'(k)];
				if (k == KIND_KEY) rq.value_high = stored_hi;
			end else begin
				rq.value_low = stored_lo[int'(k)];
				rq.value_high = stored_hi;
				pos = $urandom_range(0, (k == KIND_KEY) ? 127 : 63);
				if (pos < 64) rq.value_low[pos] = ~rq.value_low[pos];
				else rq.value_high[pos - 64] = ~rq.value_high[pos - 64];
			end
		end else if (r < 85) begin
			rq.req_type = $urandom_range(0, 1) ? REQ_SET : REQ_VERIFY;
			rq.ref_kind = k;
			rq.value_length = LEN_W'((kind_bytes(k) + $urandom_range(1, 31)) % 32);
		end else if (r < 92) begin
			rq.req_type = $urandom_range(0, 1) ? REQ_SET : REQ_VERIFY;
			rq.ref_kind = KIND_BAD;
		end else begin
			rq.req_type = REQ_UNDEF;
		end
		return rq;
	endfunction

	task automatic send(input req_t rq, input bit drain = 1'b0);
		backlog_t b;
		if (rq.req_type == REQ_SET && rq.ref_kind != KIND_BAD
				&& int'(rq.value_length) == kind_bytes(rq.ref_kind)) begin
			stored_lo[int'(rq.ref_kind)] = rq.value_low;
			if (rq.ref_kind == KIND_KEY) stored_hi = rq.value_high;
		end
		b.rq = rq;
		b.drain = drain;
		req_backlog.push_back(b);
	endtask

	task automatic reg_write(input reg_idx_t idx, input logic [CNT_W-1:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= DATA_W'(val);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		retry_limit[int'(idx)] = val;
	endtask

	task automatic set_limits(input logic [CNT_W-1:0] pin_max, input logic [CNT_W-1:0] puk_max,
			input logic [CNT_W-1:0] key_max);
		reg_write(REG_PIN_MAX, pin_max);
		reg_write(REG_PUK_MAX, puk_max);
		reg_write(REG_KEY_MAX, key_max);
	endtask

	task automatic drain_all();
		while (req_backlog.size() != 0 || auth_expected.size() != 0 || in_valid)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Sender: one beat per accepted request, with random gaps while idle_on is set.
	always @(posedge clk or negedge arst_n) begin : sender
		logic offer;
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left = 0;
		end else begin
			offer = in_valid;
			if (in_valid && !in_stall) begin
				auth_expected.push_back(auth_outcome(drv));
				offer = 1'b0;
				gap_left = idle_on ? rand_gap() : 0;
			end
			if (!offer) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (req_backlog.size() != 0
						&& (!req_backlog[0].drain || auth_expected.size() == 0)) begin
					drv <= req_backlog[0].rq;
					void'(req_backlog.pop_front());
					offer = 1'b1;
				end
			end
			in_valid <= offer;
		end
	end

	// Receiver: checks each result beat and applies random or long back-pressure.
	always @(posedge clk or negedge arst_n) begin : receiver
		rsp_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (auth_expected.size() == 0) begin
					$error("result beat with nothing expected");
					errors++;
				end else begin
					want = auth_expected.pop_front();
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						errors++;
					end
					if (tries_left !== want.tries_left) begin
						$error("tries_left: expected %0d, got %0d", want.tries_left, tries_left);
						errors++;
					end
					if (pin_verified !== want.pin_verified) begin
						$error("pin_verified: expected %0d, got %0d",
							want.pin_verified, pin_verified);
						errors++;
					end
					if (key_verified !== want.key_verified) begin
						$error("key_verified: expected %0d, got %0d",
							want.key_verified, key_verified);
						errors++;
					end
				end
			end
			if (hold_req) begin
				stall_left = LONG_HOLD;
				hold_req = 1'b0;
			end
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
				stall_left = idle_on ? rand_gap() : 0;
			end
		end
	end

	initial begin
		#2_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		pin_ok = 1'b0;
		key_ok = 1'b0;
		for (int i = 0; i < 3; i++) begin
			retry_cnt[i] = '0;
			stored_lo[i] = '0;
		end
		for (int i = 0; i < 4; i++) ref_word[i] = '0;
		stored_hi = '0;
		retry_limit[0] = 4'd3;
		retry_limit[1] = 4'd10;
		retry_limit[2] = 4'd3;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Reset limits: access checks, a blocked PIN, length and kind errors, then
		// set and verify each kind through match and mismatch, and exhaust the PIN.
		send(item(REQ_CHECK, KIND_PIN, ACC_ALWAYS, '0, '0, 0));
		send(item(REQ_CHECK, KIND_BAD, ACC_NEVER, '1, '1, 31));
		send(item(REQ_CHECK, KIND_PIN, ACC_PIN, '0, '0, 0));
		send(item(REQ_CHECK, KIND_KEY, acc_cond_t'(3'd7), '0, '0, 0));
		send(item(REQ_VERIFY, KIND_PIN, ACC_NEVER, '1, '0, PIN_LEN));
		send(item(REQ_SET, KIND_PIN, ACC_NEVER, '1, '0, 0));
		send(item(REQ_SET, KIND_BAD, ACC_NEVER, '1, '1, KEY_LEN));
		send(item(REQ_UNDEF, KIND_PIN, ACC_ALWAYS, '1, '1, PIN_LEN));
		send(item(REQ_SET, KIND_PIN, ACC_NEVER, '1, '1, PIN_LEN));
		send(item(REQ_SET, KIND_PUK, ACC_NEVER, '0, '1, PUK_LEN));
		send(item(REQ_SET, KIND_KEY, ACC_NEVER, '1, '0, KEY_LEN));
		send(item(REQ_VERIFY, KIND_PIN, ACC_NEVER, '0, '0, PIN_LEN));
		send(item(REQ_VERIFY, KIND_PIN, ACC_NEVER, '1, '0, PIN_LEN));
		send(item(REQ_CHECK, KIND_PIN, ACC_PIN_AND_KEY, '0, '0, 0));
		send(item(REQ_VERIFY, KIND_KEY, ACC_NEVER, '1, '0, KEY_LEN));
		send(item(REQ_CHECK, KIND_PIN, ACC_PIN_AND_KEY, '0, '0, 0));
		send(item(REQ_CHECK, KIND_PIN, ACC_PIN_OR_KEY, '0, '0, 0));
		send(item(REQ_CHECK, KIND_PIN, ACC_KEY, '0, '0, 0));
		send(item(REQ_VERIFY, KIND_PUK, ACC_NEVER, 64'd1, '0, PUK_LEN));
		send(item(REQ_VERIFY, KIND_PUK, ACC_NEVER, '0, '1, PUK_LEN));
		send(item(REQ_VERIFY, KIND_KEY, ACC_NEVER, '1, 64'h8000_0000_0000_0000, KEY_LEN));
		send(item(REQ_VERIFY, KIND_PIN, ACC_NEVER, '1, '0, 31));
		send(item(REQ_SET, KIND_PIN, ACC_NEVER, 64'h5555_5555_5555_5555, '0, PIN_LEN));
		repeat (4) send(item(REQ_VERIFY, KIND_PIN, ACC_NEVER, '0, '0, PIN_LEN));
		drain_all();

		// Largest limits; the receiver holds off long enough to back the block up.
		set_limits(4'd15, 4'd15, 4'd15);
		for (int i = 0; i < 300; i++) send(make_item());
		@(negedge clk) hold_req = 1'b1;
		drain_all();

		// Smallest limits; now and then the sender waits for the block to empty.
		set_limits(4'd1, 4'd1, 4'd1);
		for (int i = 0; i < 300; i++) send(make_item(), $urandom_range(0, 49) == 0);
		drain_all();

		// A zero PIN limit leaves the PIN blocked even after a set.
		set_limits(4'd0, 4'd7, 4'd2);
		send(item(REQ_SET, KIND_PIN, ACC_NEVER, 64'h0123_4567_89AB_CDEF, '0, PIN_LEN));
		send(item(REQ_VERIFY, KIND_PIN, ACC_NEVER, 64'h0123_4567_89AB_CDEF, '0, PIN_LEN));
		for (int i = 0; i < 250; i++) send(make_item());
		drain_all();

		// Random limits with both sides running flat out.
		set_limits(4'($urandom_range(1, 15)), 4'($urandom_range(1, 15)),
			4'($urandom_range(1, 15)));
		idle_on = 1'b0;
		for (int i = 0; i < 300; i++) send(make_item());
		drain_all();

		repeat (8) @(posedge clk);
		if (errors == 0 && auth_expected.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

[sim.f]
rtl/pra_pkg.sv
rtl/pra_cfg_regs.sv
rtl/pra_auth_core.sv
rtl/pin_retry_auth_unit_top.sv
bench/tb.sv
